### rtl/drg_pkg.sv
package drg_pkg;

    localparam int unsigned LimitWidth = 16;
    localparam logic [LimitWidth-1:0] LimitReset = 16'd500;
    localparam logic [LimitWidth-1:0] TicksMax = 16'hFFFF;

    typedef enum logic [1:0]
    {
        SIDE_NONE = 2'd0,
        SIDE_UP   = 2'd1,
        SIDE_DOWN = 2'd2
    } side_t;

    typedef enum logic [1:0]
    {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        BTN_LEFT_UP    = 2'd0,
        BTN_LEFT_DOWN  = 2'd1,
        BTN_RIGHT_UP   = 2'd2,
        BTN_RIGHT_DOWN = 2'd3
    } button_t;

    typedef enum logic [2:0]
    {
        G_BOTH_UP    = 3'd0,
        G_BOTH_DOWN  = 3'd1,
        G_LDOWN_RUP  = 3'd2,
        G_LUP_RDOWN  = 3'd3,
        G_LEFT_UP    = 3'd4,
        G_LEFT_DOWN  = 3'd5,
        G_RIGHT_UP   = 3'd6,
        G_RIGHT_DOWN = 3'd7
    } gesture_t;

    typedef struct packed
    {
        side_t                 left_side;
        side_t                 right_side;
        logic                  timer_running;
        logic [LimitWidth-1:0] held_ticks;
    } rocker_state_t;

    typedef struct packed
    {
        logic     valid;
        gesture_t gesture;
        logic     is_long;
    } result_t;

endpackage

### rtl/drg_core.sv
module drg_core
(
    input  drg_pkg::rocker_state_t          cur,
    input  drg_pkg::op_t                    op,
    input  drg_pkg::button_t                button,
    input  logic [drg_pkg::LimitWidth-1:0]  limit,
    output drg_pkg::rocker_state_t          nxt,
    output drg_pkg::result_t                res
);

    logic                           finish;
    logic                           finish_long;
    logic [drg_pkg::LimitWidth-1:0] ticks_inc;
    drg_pkg::gesture_t              gesture;
    logic                           any_side;

    always_comb
    begin
        if ((cur.left_side != drg_pkg::SIDE_NONE) && (cur.right_side != drg_pkg::SIDE_NONE))
        begin
            if ((cur.left_side == drg_pkg::SIDE_UP) && (cur.right_side == drg_pkg::SIDE_UP))
                gesture = drg_pkg::G_BOTH_UP;
            else if ((cur.left_side == drg_pkg::SIDE_DOWN)
                     && (cur.right_side == drg_pkg::SIDE_DOWN))
                gesture = drg_pkg::G_BOTH_DOWN;
            else if (cur.left_side == drg_pkg::SIDE_DOWN)
                gesture = drg_pkg::G_LDOWN_RUP;
            else
                gesture = drg_pkg::G_LUP_RDOWN;
        end
        else if (cur.left_side != drg_pkg::SIDE_NONE)
        begin
            gesture = (cur.left_side == drg_pkg::SIDE_UP) ? drg_pkg::G_LEFT_UP
                                                          : drg_pkg::G_LEFT_DOWN;
        end
        else
        begin
            gesture = (cur.right_side == drg_pkg::SIDE_UP) ? drg_pkg::G_RIGHT_UP
                                                           : drg_pkg::G_RIGHT_DOWN;
        end
    end

    assign any_side = (cur.left_side != drg_pkg::SIDE_NONE)
                   || (cur.right_side != drg_pkg::SIDE_NONE);

    // saturating tick count
    assign ticks_inc = (cur.held_ticks < drg_pkg::TicksMax) ? cur.held_ticks + 1'b1
                                                            : cur.held_ticks;

    always_comb
    begin
        nxt         = cur;
        finish      = 1'b0;
        finish_long = 1'b0;
        case (op)
            drg_pkg::OP_PRESS:
            begin
                if (!any_side)
                begin
                    nxt.held_ticks    = '0;
                    nxt.timer_running = 1'b1;
                end
                case (button)
                    drg_pkg::BTN_LEFT_UP:    nxt.left_side  = drg_pkg::SIDE_UP;
                    drg_pkg::BTN_LEFT_DOWN:  nxt.left_side  = drg_pkg::SIDE_DOWN;
                    drg_pkg::BTN_RIGHT_UP:   nxt.right_side = drg_pkg::SIDE_UP;
                    default:                 nxt.right_side = drg_pkg::SIDE_DOWN;
                endcase
            end
            drg_pkg::OP_RELEASE:
            begin
                finish = cur.timer_running;
            end
            drg_pkg::OP_TICK:
            begin
                if (cur.timer_running)
                begin
                    nxt.held_ticks = ticks_inc;
                    if (ticks_inc >= limit)
                    begin
                        finish      = 1'b1;
                        finish_long = 1'b1;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        if (finish)
        begin
            nxt.left_side     = drg_pkg::SIDE_NONE;
            nxt.right_side    = drg_pkg::SIDE_NONE;
            nxt.timer_running = 1'b0;
        end
    end

    assign res.valid   = finish && any_side;
    assign res.gesture = gesture;
    assign res.is_long = finish_long;

endmodule

### rtl/dual_rocker_gesture_decoder.sv
// Gesture decoder for a double rocker switch. Each input word is a press, a release
// or a one-millisecond tick; a release before long_press_ticks ticks gives a short
// gesture, reaching the limit while held gives a long one. The combinational update
// logic takes one word each cycle unless an untaken gesture holds the result register;
// a gesture appears on the master side in the cycle after the word that ends it and
// waits in the result register, which lets the next word in as it is taken. The user
// must write long_press_ticks on the cfg channel while the block is idle, unenforced.
module dual_rocker_gesture_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // button[1:0], zero fill
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // gesture[2:0], zero fill
    output logic        m_tuser,   // is_long
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // long_press_ticks
);

    drg_pkg::rocker_state_t         state_reg;
    drg_pkg::rocker_state_t         state_next;
    drg_pkg::result_t               res;
    logic [drg_pkg::LimitWidth-1:0] limit_reg;
    logic                           out_valid_reg;
    drg_pkg::gesture_t              gesture_reg;
    logic                           is_long_reg;
    logic                           s_accept;
    drg_pkg::op_t                   op;
    drg_pkg::button_t               button;

    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign op        = drg_pkg::op_t'(s_tuser);
    assign button    = drg_pkg::button_t'(s_tdata[1:0]);

    drg_core u_core
    (
        .cur    (state_reg),
        .op     (op),
        .button (button),
        .limit  (limit_reg),
        .nxt    (state_next),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.left_side     <= drg_pkg::SIDE_NONE;
            state_reg.right_side    <= drg_pkg::SIDE_NONE;
            state_reg.timer_running <= 1'b0;
            state_reg.held_ticks    <= '0;
            limit_reg               <= drg_pkg::LimitReset;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (s_accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= res.valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && res.valid)
        begin
            gesture_reg <= res.gesture;
            is_long_reg <= res.is_long;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, gesture_reg};
    assign m_tuser  = is_long_reg;

`ifndef ASSERT_OFF
    a_idle_sides: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.timer_running |->
            (state_reg.left_side == drg_pkg::SIDE_NONE)
            && (state_reg.right_side == drg_pkg::SIDE_NONE))
        else $error("sides set while timer stopped");

    a_press_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (op == drg_pkg::OP_PRESS)) |=> !m_tvalid)
        else $error("press produced a gesture");

    a_stray_release: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (op == drg_pkg::OP_RELEASE) && !state_reg.timer_running)
            |=> !m_tvalid)
        else $error("release without timer produced a gesture");

    a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && res.valid) |=> !state_reg.timer_running)
        else $error("timer still running after gesture");
`endif

endmodule
